// ===== src/icc_pkg.sv =====
// shared types, character constants and helper functions of the identifier case converter
package icc_pkg;

	// character codes
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHAR_SPACE      = 8'h20;
	localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
	localparam logic [7:0] CASE_DELTA      = 8'd32;

	// conversion mode carried with every character
	typedef enum logic [1:0] {
		MODE_SNAKE   = 2'd0,
		MODE_CAMEL   = 2'd1,
		MODE_PASCAL  = 2'd2,
		MODE_INVALID = 2'd3
	} mode_t;

	// end of packet status
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_EDGE_SEP = 2'd1,
		STAT_BAD_MODE = 2'd2
	} status_t;

	// one converted request and the next value of the packet state
	typedef struct packed {
		logic    ins;
		logic    keep;
		logic    emit;
		logic [7:0] ch;
		status_t status;
		logic    cap_nxt;
		logic    fws_nxt;
	} conv_t;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CHAR_UNDERSCORE) || (c == CHAR_SPACE);
	endfunction

endpackage

// ===== src/icc_conv.sv =====
// combinational case conversion of one registered character
module icc_conv (
	input  logic [7:0]     char_in,
	input  icc_pkg::mode_t mode,
	input  logic           first_char,
	input  logic           last_char,
	input  logic           cap_q,
	input  logic           fws_q,
	output icc_pkg::conv_t res
);

	logic [7:0] c;
	logic       keep;
	logic       ins;
	logic       cap_in;
	logic       cap_nxt;
	logic       fws_nxt;
	icc_pkg::status_t status;

	// first character restarts the packet state
	assign cap_in  = first_char ? 1'b0 : cap_q;
	assign fws_nxt = first_char ? icc_pkg::is_sep(char_in) : fws_q;

	// per mode rewrite
	always_comb begin
		c       = char_in;
		keep    = 1'b1;
		ins     = 1'b0;
		cap_nxt = cap_in;
		unique case (mode)
			icc_pkg::MODE_SNAKE: begin
				if (icc_pkg::is_upper(char_in)) begin
					c   = char_in + icc_pkg::CASE_DELTA;
					ins = !first_char;
				end else if (char_in == icc_pkg::CHAR_SPACE) begin
					c = icc_pkg::CHAR_UNDERSCORE;
				end
			end
			icc_pkg::MODE_CAMEL: begin
				if (icc_pkg::is_sep(char_in)) begin
					keep    = 1'b0;
					cap_nxt = 1'b1;
				end else begin
					if (cap_in && icc_pkg::is_lower(char_in)) begin
						c = char_in - icc_pkg::CASE_DELTA;
					end
					cap_nxt = 1'b0;
					if (first_char && icc_pkg::is_upper(char_in)) begin
						c = char_in + icc_pkg::CASE_DELTA;
					end
				end
			end
			icc_pkg::MODE_PASCAL: begin
				if (first_char) begin
					if (icc_pkg::is_lower(char_in)) begin
						c = char_in - icc_pkg::CASE_DELTA;
					end
				end else if (char_in == icc_pkg::CHAR_UNDERSCORE) begin
					keep    = 1'b0;
					cap_nxt = 1'b1;
				end else begin
					if (cap_in && icc_pkg::is_lower(char_in)) begin
						c = char_in - icc_pkg::CASE_DELTA;
					end
					cap_nxt = 1'b0;
				end
			end
			default: begin
				c = char_in;
			end
		endcase
	end

	// status priority: leading separator, bad mode, trailing separator
	always_comb begin
		status = icc_pkg::STAT_OK;
		if (last_char) begin
			if (fws_nxt) begin
				status = icc_pkg::STAT_EDGE_SEP;
			end else if (mode == icc_pkg::MODE_INVALID) begin
				status = icc_pkg::STAT_BAD_MODE;
			end else if (icc_pkg::is_sep(char_in)) begin
				status = icc_pkg::STAT_EDGE_SEP;
			end
		end
	end

	assign res.ins     = ins;
	assign res.keep    = keep;
	assign res.emit    = keep || last_char;
	assign res.ch      = keep ? c : 8'd0;
	assign res.status  = status;
	assign res.cap_nxt = cap_nxt;
	assign res.fws_nxt = fws_nxt;

endmodule

// ===== src/identifier_case_converter.sv =====
// top level of the identifier case converter: input register, conversion, result register
//
//  channel | direction | tdata          | tuser                          | tlast
//  s_axis  | in        | char_in [7:0]  | mode [1:0], first_char [2]     | last_char
//  m_axis  | out       | char_out [7:0] | char_valid [0], status [2:1]   | end_of_packet
//
// one request per cycle unless the result register stalls; a snake-mode capital that
// is not first holds the input stage while the inserted '_' goes into it first, since the
// inserted '_' and the character share the single result register
// arst_n clears the valid flags and the packet state; no clearing pass
// a stalled result register holds an input stage that emits, which then holds s_tready low
module identifier_case_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic [2:0] s_tuser,   // [1:0] mode, [2] first_char
	input  logic       s_tlast,   // last_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] char_out
	output logic [2:0] m_tuser,   // [0] char_valid, [2:1] status
	output logic       m_tlast    // end_of_packet
);

	logic           s1_valid_q;
	logic [7:0]     char_s1;
	icc_pkg::mode_t mode_s1;
	logic           first_s1;
	logic           last_s1;
	logic           ins_done_q;
	logic           cap_q;
	logic           fws_q;

	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_cvalid_q;
	logic             out_eop_q;
	icc_pkg::status_t out_stat_q;

	icc_pkg::conv_t res;
	logic           out_free;
	logic           ins_pend;
	logic           s1_done;
	logic           s_accept;

	// conversion of the registered character
	icc_conv u_conv (
		.char_in    (char_s1),
		.mode       (mode_s1),
		.first_char (first_s1),
		.last_char  (last_s1),
		.cap_q      (cap_q),
		.fws_q      (fws_q),
		.res        (res)
	);

	// handshake and stage advance
	assign out_free = !out_valid_q || m_tready;
	assign ins_pend = s1_valid_q && res.ins && !ins_done_q;
	assign s1_done  = s1_valid_q && !ins_pend && (out_free || !res.emit);
	assign s_tready = !s1_valid_q || s1_done;
	assign s_accept = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			char_s1  <= s_tdata;
			mode_s1  <= icc_pkg::mode_t'(s_tuser[1:0]);
			first_s1 <= s_tuser[2];
			last_s1  <= s_tlast;
		end
	end

	// packet state and insertion progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= 1'b0;
			fws_q      <= 1'b0;
			ins_done_q <= 1'b0;
		end else begin
			if (s1_done) begin
				cap_q      <= res.cap_nxt;
				fws_q      <= res.fws_nxt;
				ins_done_q <= 1'b0;
			end else if (ins_pend && out_free) begin
				ins_done_q <= 1'b1;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= ins_pend || (s1_valid_q && res.emit);
		end
	end

	// result register payload: inserted '_' first, then the character itself
	always_ff @(posedge clk) begin
		if (out_free && ins_pend) begin
			out_char_q   <= icc_pkg::CHAR_UNDERSCORE;
			out_cvalid_q <= 1'b1;
			out_eop_q    <= 1'b0;
			out_stat_q   <= icc_pkg::STAT_OK;
		end else if (out_free && s1_valid_q && res.emit) begin
			out_char_q   <= res.ch;
			out_cvalid_q <= res.keep;
			out_eop_q    <= last_s1;
			out_stat_q   <= res.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = {out_stat_q, out_cvalid_q};
	assign m_tlast  = out_eop_q;

endmodule

// ===== src/icc_checker.sv =====
// port level checks of the identifier case converter and their binding
module icc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic       m_tlast
);

	// status is reported only on the end of packet result
	a_status_on_eop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[2:1] == 2'd0)
		else $error("status set on a result without end of packet");

	// a result without a character only closes a packet
	a_empty_is_eop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("status-only result without end of packet");

	// a status-only result carries a zero character
	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("status-only result with nonzero character");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind identifier_case_converter icc_checker u_icc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== dv/icc_stream_checker.sv =====
// stream checker for the identifier case converter: predicts every result and compares it
`timescale 1ns / 1ps

module icc_stream_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic [2:0] s_tuser,   // [1:0] mode, [2] first_char
	input  logic       s_tlast,   // last_char
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] char_out
	input  logic [2:0] m_tuser,   // [0] char_valid, [2:1] status
	input  logic       m_tlast,   // end_of_packet
	output int         mismatches,
	output int         pending
);

	// one predicted result request
	typedef struct packed {
		logic [7:0]       ch;
		logic             kept;
		logic             eop;
		icc_pkg::status_t st;
	} char_result_t;

	char_result_t expected_chars[$];

	// predicted packet state
	logic cap_pending;
	logic lead_sep;

	function automatic logic upper_letter(input logic [7:0] c);
		return c >= icc_pkg::CHAR_UPPER_A && c <= icc_pkg::CHAR_UPPER_Z;
	endfunction

	function automatic logic lower_letter(input logic [7:0] c);
		return c >= icc_pkg::CHAR_LOWER_A && c <= icc_pkg::CHAR_LOWER_Z;
	endfunction

	function automatic logic separator_char(input logic [7:0] c);
		return c == icc_pkg::CHAR_UNDERSCORE || c == icc_pkg::CHAR_SPACE;
	endfunction

	// convert one accepted character and queue the results it causes
	task automatic convert_char(input logic [7:0] raw, input icc_pkg::mode_t md,
		input logic first, input logic last);
		logic [7:0] ch;
		logic keep;
		logic ins;
		icc_pkg::status_t st;
		char_result_t r;
		ch = raw;
		keep = 1'b1;
		ins = 1'b0;
		st = icc_pkg::STAT_OK;
		if (first) begin
			cap_pending = 1'b0;
			lead_sep = separator_char(raw);
		end
		case (md)
			icc_pkg::MODE_SNAKE: begin
				if (upper_letter(ch)) begin
					ch = ch + icc_pkg::CASE_DELTA;
					ins = !first;
				end else if (ch == icc_pkg::CHAR_SPACE) begin
					ch = icc_pkg::CHAR_UNDERSCORE;
				end
			end
			icc_pkg::MODE_CAMEL: begin
				if (separator_char(ch)) begin
					keep = 1'b0;
					cap_pending = 1'b1;
				end else begin
					if (cap_pending && lower_letter(ch))
						ch = ch - icc_pkg::CASE_DELTA;
					cap_pending = 1'b0;
					if (first && upper_letter(ch))
						ch = ch + icc_pkg::CASE_DELTA;
				end
			end
			icc_pkg::MODE_PASCAL: begin
				// the first character is kept even when it is a separator
				if (first) begin
					if (lower_letter(ch))
						ch = ch - icc_pkg::CASE_DELTA;
				end else if (ch == icc_pkg::CHAR_UNDERSCORE) begin
					keep = 1'b0;
					cap_pending = 1'b1;
				end else begin
					if (cap_pending && lower_letter(ch))
						ch = ch - icc_pkg::CASE_DELTA;
					cap_pending = 1'b0;
				end
			end
			default: begin
			end
		endcase
		// status priority: leading separator, bad mode, trailing separator
		if (last) begin
			if (lead_sep)
				st = icc_pkg::STAT_EDGE_SEP;
			else if (md == icc_pkg::MODE_INVALID)
				st = icc_pkg::STAT_BAD_MODE;
			else if (separator_char(raw))
				st = icc_pkg::STAT_EDGE_SEP;
		end
		if (ins) begin
			r.ch = icc_pkg::CHAR_UNDERSCORE;
			r.kept = 1'b1;
			r.eop = 1'b0;
			r.st = icc_pkg::STAT_OK;
			expected_chars.push_back(r);
		end
		if (keep || last) begin
			r.ch = keep ? ch : 8'h00;
			r.kept = keep;
			r.eop = last;
			r.st = st;
			expected_chars.push_back(r);
		end
	endtask

	// compare one result request with the oldest prediction
	task automatic check_result;
		char_result_t want;
		if (expected_chars.size() == 0) begin
			mismatches++;
			if (mismatches <= 50)
				$display("%0t ns: unexpected result: got char %h valid %b eop %b status %0d",
					$time, m_tdata, m_tuser[0], m_tlast, m_tuser[2:1]);
			return;
		end
		want = expected_chars.pop_front();
		if (m_tdata !== want.ch || m_tuser[0] !== want.kept || m_tlast !== want.eop ||
			m_tuser[2:1] !== want.st) begin
			mismatches++;
			if (mismatches <= 50)
				$display("%0t ns: result mismatch: expected char %h valid %b eop %b status %0d, %s",
					$time, want.ch, want.kept, want.eop, want.st,
					$sformatf("got char %h valid %b eop %b status %0d",
						m_tdata, m_tuser[0], m_tlast, m_tuser[2:1]));
		end
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_pending = 1'b0;
			lead_sep = 1'b0;
			expected_chars.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				convert_char(s_tdata, icc_pkg::mode_t'(s_tuser[1:0]), s_tuser[2], s_tlast);
			pending = expected_chars.size();
		end
	end

endmodule

// ===== dv/tb_identifier_case_converter.sv =====
// testbench top for the identifier case converter: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_identifier_case_converter;

	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] char_in
	logic [2:0] s_tuser = 3'b000;  // [1:0] mode, [2] first_char
	logic       s_tlast = 1'b0;    // last_char
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] char_out
	logic [2:0] m_tuser;           // [0] char_valid, [2:1] status
	logic       m_tlast;           // end_of_packet

	int mismatches;
	int pending;
	int hold_asks = 0;
	int burst_left = 0;
	logic valid_up = 1'b0;

	identifier_case_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	icc_stream_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("identifier_case_converter regression: fail");
		$finish;
	end

	// receiver stall pattern, with a long hold whenever one is asked for
	initial begin : rx_pattern
		int style;
		int span;
		int hold_seen;
		logic rdy;
		hold_seen = 0;
		@(posedge arst_n);
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(4, 60);
			repeat (span) begin
				@(posedge clk);
				if (hold_seen != hold_asks) begin
					hold_seen = hold_asks;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (style)
					0: rdy = 1'b1;
					1: rdy = $urandom_range(0, 1);
					2: rdy = ($urandom_range(0, 3) == 0);
					default: rdy = ~m_tready;
				endcase
				m_tready <= rdy;
			end
		end
	end

	// offer one character request and wait for it to be taken, idling between bursts
	task automatic offer(input logic [7:0] ch, input icc_pkg::mode_t md, input logic first,
		input logic last);
		s_tdata <= ch;
		s_tuser <= {first, md};
		s_tlast <= last;
		s_tvalid <= 1'b1;
		valid_up = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			valid_up = 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 20);
		end
	endtask

	// stop sending until every predicted result has come out
	task automatic drain_results;
		if (valid_up) begin
			s_tvalid <= 1'b0;
			valid_up = 1'b0;
		end
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// mostly identifier characters, sometimes any byte
	function automatic logic [7:0] ident_char();
		int r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 35)
			c = icc_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
		else if (r < 55)
			c = icc_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
		else if (r < 70)
			c = icc_pkg::CHAR_UNDERSCORE;
		else if (r < 80)
			c = icc_pkg::CHAR_SPACE;
		else if (r < 90)
			c = 8'h30 + 8'($urandom_range(0, 9));
		else
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic icc_pkg::mode_t pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return icc_pkg::MODE_SNAKE;
		else if (r < 60)
			return icc_pkg::MODE_CAMEL;
		else if (r < 90)
			return icc_pkg::MODE_PASCAL;
		return icc_pkg::MODE_INVALID;
	endfunction

	// stimulus and verdict
	initial begin : stimulus
		int kind;
		int len;
		int packets;
		int sent;
		icc_pkg::mode_t md;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 20);

		// snake: capital first, space, capital last gets an inserted '_'
		offer("Z", icc_pkg::MODE_SNAKE, 1'b1, 1'b0);
		offer("a", icc_pkg::MODE_SNAKE, 1'b0, 1'b0);
		offer(" ", icc_pkg::MODE_SNAKE, 1'b0, 1'b0);
		offer("A", icc_pkg::MODE_SNAKE, 1'b0, 1'b1);
		// camel: capital first, separator run, dropped trailing separator
		offer("Q", icc_pkg::MODE_CAMEL, 1'b1, 1'b0);
		offer("_", icc_pkg::MODE_CAMEL, 1'b0, 1'b0);
		offer(" ", icc_pkg::MODE_CAMEL, 1'b0, 1'b0);
		offer("z", icc_pkg::MODE_CAMEL, 1'b0, 1'b0);
		offer("_", icc_pkg::MODE_CAMEL, 1'b0, 1'b1);
		// pascal: leading '_' is kept and flagged
		offer("_", icc_pkg::MODE_PASCAL, 1'b1, 1'b0);
		offer("a", icc_pkg::MODE_PASCAL, 1'b0, 1'b0);
		offer("_", icc_pkg::MODE_PASCAL, 1'b0, 1'b0);
		offer("b", icc_pkg::MODE_PASCAL, 1'b0, 1'b1);
		// pascal: lowercase first, space kept
		offer("a", icc_pkg::MODE_PASCAL, 1'b1, 1'b0);
		offer(" ", icc_pkg::MODE_PASCAL, 1'b0, 1'b0);
		offer("c", icc_pkg::MODE_PASCAL, 1'b0, 1'b1);
		// invalid mode passes bytes through
		offer(8'h00, icc_pkg::MODE_INVALID, 1'b1, 1'b0);
		offer(8'hFF, icc_pkg::MODE_INVALID, 1'b0, 1'b0);
		offer("a", icc_pkg::MODE_INVALID, 1'b0, 1'b1);
		// single character that is both first and last
		offer(" ", icc_pkg::MODE_SNAKE, 1'b1, 1'b1);
		// last with no first: the leading separator flag is carried over
		offer("x", icc_pkg::MODE_CAMEL, 1'b0, 1'b1);
		offer(8'h60, icc_pkg::MODE_INVALID, 1'b1, 1'b1);
		// characters just outside the letter ranges
		offer("@", icc_pkg::MODE_CAMEL, 1'b1, 1'b0);
		offer("[", icc_pkg::MODE_CAMEL, 1'b0, 1'b0);
		offer(8'h60, icc_pkg::MODE_CAMEL, 1'b0, 1'b0);
		offer("{", icc_pkg::MODE_CAMEL, 1'b0, 1'b1);
		drain_results();

		// random packets
		packets = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
			md = pick_mode();
			for (int i = 0; i < len; i++) begin
				if (kind < 70)
					offer(ident_char(), md, i == 0, i == len - 1);
				else if (kind < 85)
					offer(ident_char(), pick_mode(), i == 0, i == len - 1);
				else
					offer(8'($urandom_range(0, 255)),
						icc_pkg::mode_t'(2'($urandom_range(0, 3))),
						$urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
				sent++;
			end
			packets++;
			if (packets == 25 || packets == 120)
				hold_asks++;
			if (packets == 60 || packets == 150)
				drain_results();
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("identifier_case_converter regression: pass");
		else
			$display("identifier_case_converter regression: fail");
		$finish;
	end

endmodule
